### rtl/core/w8u16_pkg.sv
// ----------------------------------------------------------------------------
// w8u16_pkg
// Shared types and constants for the WTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package w8u16_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h010000;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

    // byte classes
    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [4:0] SURR_TAG  = 5'b11011;

    // first continuation check
    localparam logic [1:0] OL_NONE = 2'd0;
    localparam logic [1:0] OL_BIT5 = 2'd1;
    localparam logic [1:0] OL_BITS45 = 2'd2;

    // up to three code units caused by one input byte
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic [15:0] unit2;
        logic        last;
        logic        bad;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

### rtl/core/wtf8_to_utf16_decoder_unit.sv
// ----------------------------------------------------------------------------
// wtf8_to_utf16_decoder_unit
// WTF-8 byte stream in, UTF-16 code units out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle as long as the bundle queue has room. Each
// byte makes zero to three code units; the output side sends one unit per
// cycle while m_tready is high, so a run of bytes that each expand to
// several units is limited by the output port and is absorbed by the
// QUEUE_DEPTH-entry queue. With an idle queue a byte's bundle is written
// into the queue and then loaded into the back part's register before its
// first unit is driven on the m_ side.
// An invalid string gives one unit with tuser set, tlast set and data zero;
// later bytes up to the string's tlast give nothing.
module wtf8_to_utf16_decoder_unit #(
    parameter int QUEUE_DEPTH = w8u16_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_unit
    output logic        m_tlast,
    output logic        m_tuser    // bad_input
);
    import w8u16_pkg::*;

    queue_status_t q_status;
    bundle_t       push_data;
    bundle_t       pop_data;
    logic          push;
    logic          pop;

    w8u16_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .end_of_string (s_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    w8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    w8u16_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .code_unit (m_tdata),
        .last_unit (m_tlast),
        .bad_input (m_tuser)
    );

endmodule

### rtl/core/w8u16_front.sv
// ----------------------------------------------------------------------------
// w8u16_front
// Accepts bytes, tracks the decode state and packs each byte's code units
// into one bundle for the queue.
// ----------------------------------------------------------------------------
module w8u16_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    end_of_string,
    input  w8u16_pkg::queue_status_t q_status,
    output logic                    push,
    output w8u16_pkg::bundle_t      push_data
);
    import w8u16_pkg::*;

    logic [1:0]  remain_reg, remain_next;
    logic [20:0] accum_reg, accum_next;
    logic [1:0]  ol_reg, ol_next;
    logic [9:0]  held_bits_reg, held_bits_next;
    logic        held_reg, held_next;
    logic        discard_reg, discard_next;

    logic        take;
    logic        fail;
    logic        complete;
    logic [20:0] cp;
    logic [20:0] cont_accum;
    logic [1:0]  cont_remain;
    logic [5:0]  ol_mask;
    logic [20:0] supp;
    logic        is_big;
    logic        is_surr;
    logic [15:0] body0, body1;
    logic [1:0]  body_count;
    bundle_t     bundle;

    assign in_ready = !q_status.full;
    assign take     = in_valid && in_ready;

    assign cont_accum  = {accum_reg[14:0], in_byte[5:0]};
    assign cont_remain = remain_reg - 2'd1;
    assign supp        = cp - SUPP_BASE;
    assign is_big      = cp > {5'd0, 16'hFFFF};
    assign is_surr     = !is_big && (cp[15:11] == SURR_TAG);

    always_comb begin
        case (ol_reg)
            OL_NONE: ol_mask = 6'h00;
            OL_BIT5: ol_mask = 6'h20;
            default: ol_mask = 6'h30;
        endcase
    end

    always_comb begin
        remain_next    = remain_reg;
        accum_next     = accum_reg;
        ol_next        = ol_reg;
        held_bits_next = held_bits_reg;
        held_next      = held_reg;
        discard_next   = discard_reg;
        fail           = 1'b0;
        complete       = 1'b0;
        cp             = {13'd0, in_byte};
        body0          = 16'd0;
        body1          = 16'd0;
        body_count     = 2'd0;
        bundle         = '0;
        push           = 1'b0;

        if (take) begin
            if (discard_reg) begin
                if (end_of_string) begin
                    discard_next = 1'b0;
                end
            end else if (!in_byte[7]) begin
                if (remain_reg != 2'd0) begin
                    fail = 1'b1;
                end else begin
                    complete = 1'b1;
                end
            end else if (in_byte[7:6] == CONT_TAG) begin
                if (remain_reg == 2'd0 || (in_byte[5:0] & ol_mask) == 6'h00 && ol_mask != 6'h00)
                begin
                    fail = 1'b1;
                end else if (cont_remain != 2'd0) begin
                    if (end_of_string) begin
                        fail = 1'b1;
                    end else begin
                        accum_next  = cont_accum;
                        remain_next = cont_remain;
                        ol_next     = OL_NONE;
                    end
                end else if (cont_accum > MAX_CODE_POINT) begin
                    fail = 1'b1;
                end else begin
                    complete = 1'b1;
                    cp       = cont_accum;
                end
            end else begin
                if (remain_reg != 2'd0 || end_of_string) begin
                    fail = 1'b1;
                end else if (in_byte[7:5] == LEAD2_TAG) begin
                    if (in_byte[4:1] == 4'd0) begin
                        fail = 1'b1;
                    end else begin
                        remain_next = 2'd1;
                        accum_next  = {16'd0, in_byte[4:0]};
                        ol_next     = OL_NONE;
                    end
                end else if (in_byte[7:4] == LEAD3_TAG) begin
                    remain_next = 2'd2;
                    accum_next  = {17'd0, in_byte[3:0]};
                    ol_next     = (in_byte[3:0] == 4'd0) ? OL_BIT5 : OL_NONE;
                end else if (in_byte[7:3] == LEAD4_TAG && in_byte[2:0] <= 3'd4) begin
                    remain_next = 2'd3;
                    accum_next  = {18'd0, in_byte[2:0]};
                    ol_next     = (in_byte[2:0] == 3'd0) ? OL_BITS45 : OL_NONE;
                end else begin
                    fail = 1'b1;
                end
            end

            if (complete) begin
                if (is_big) begin
                    body0      = HIGH_SURR_BASE | {6'd0, supp[19:10]};
                    body1      = LOW_SURR_BASE | {6'd0, supp[9:0]};
                    body_count = 2'd2;
                end else begin
                    body0      = cp[15:0];
                    body_count = (is_surr && !cp[10] && !end_of_string) ? 2'd0 : 2'd1;
                end
                if (is_surr && cp[10] && held_reg) begin
                    fail = 1'b1;
                end
            end

            if (fail) begin
                remain_next    = 2'd0;
                accum_next     = 21'd0;
                ol_next        = OL_NONE;
                held_bits_next = 10'd0;
                held_next      = 1'b0;
                discard_next   = !end_of_string;
                bundle.count   = 2'd1;
                bundle.last    = 1'b1;
                bundle.bad     = 1'b1;
                push           = 1'b1;
            end else if (complete) begin
                remain_next = 2'd0;
                accum_next  = 21'd0;
                ol_next     = OL_NONE;
                if (is_surr && !cp[10] && !end_of_string) begin
                    held_next      = 1'b1;
                    held_bits_next = cp[9:0];
                end else begin
                    held_next      = 1'b0;
                    held_bits_next = 10'd0;
                end
                if (held_reg) begin
                    bundle.unit0 = HIGH_SURR_BASE | {6'd0, held_bits_reg};
                    bundle.unit1 = body0;
                    bundle.unit2 = body1;
                    bundle.count = body_count + 2'd1;
                end else begin
                    bundle.unit0 = body0;
                    bundle.unit1 = body1;
                    bundle.count = body_count;
                end
                bundle.last = end_of_string;
                push        = bundle.count != 2'd0;
            end
        end
    end

    assign push_data = bundle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg    <= 2'd0;
            accum_reg     <= 21'd0;
            ol_reg        <= OL_NONE;
            held_bits_reg <= 10'd0;
            held_reg      <= 1'b0;
            discard_reg   <= 1'b0;
        end else begin
            remain_reg    <= remain_next;
            accum_reg     <= accum_next;
            ol_reg        <= ol_next;
            held_bits_reg <= held_bits_next;
            held_reg      <= held_next;
            discard_reg   <= discard_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        discard_reg |-> (remain_reg == 2'd0 && !held_reg))
        else $error("decode state left while discarding");

endmodule

### rtl/core/w8u16_queue.sv
// ----------------------------------------------------------------------------
// w8u16_queue
// Short bundle queue between the front and back parts.
// ----------------------------------------------------------------------------
module w8u16_queue #(
    parameter int DEPTH = w8u16_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  w8u16_pkg::bundle_t       push_data,
    input  logic                     pop,
    output w8u16_pkg::bundle_t       pop_data,
    output w8u16_pkg::queue_status_t status
);
    import w8u16_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign status.full  = count_reg == CW'(DEPTH);
    assign status.valid = count_reg != '0;
    assign pop_data     = slots_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("request pushed into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count overflow");

endmodule

### rtl/core/w8u16_back.sv
// ----------------------------------------------------------------------------
// w8u16_back
// Unpacks queued bundles and sends their code units one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module w8u16_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  w8u16_pkg::queue_status_t q_status,
    input  w8u16_pkg::bundle_t       q_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              code_unit,
    output logic                     last_unit,
    output logic                     bad_input
);
    import w8u16_pkg::*;

    bundle_t    cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       fire, final_unit, load;

    assign out_valid  = busy_reg;
    assign fire       = busy_reg && out_ready;
    assign final_unit = idx_reg == (cur_reg.count - 2'd1);
    assign load       = !busy_reg || (fire && final_unit);
    assign pop        = load && q_status.valid;

    always_comb begin
        case (idx_reg)
            2'd0:    code_unit = cur_reg.unit0;
            2'd1:    code_unit = cur_reg.unit1;
            default: code_unit = cur_reg.unit2;
        endcase
    end

    assign last_unit = cur_reg.last && final_unit;
    assign bad_input = cur_reg.bad;

    always_comb begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            busy_next = q_status.valid;
            cur_next  = q_data;
            idx_next  = 2'd0;
        end else if (fire) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cur_reg.count != 2'd0 && idx_reg < cur_reg.count))
        else $error("unit index outside bundle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cur_reg.bad) |-> (cur_reg.count == 2'd1 && last_unit && code_unit == 16'd0))
        else $error("malformed error request");

endmodule
